### sv/ctrng_pkg.sv
// ----------------------------------------------------------------------------
// ctrng_pkg
// shared types, codes and the tausworthe update function for the combined
// tausworthe generator
// ----------------------------------------------------------------------------
package ctrng_pkg;

   localparam logic [1:0] OP_RAW  = 2'd0;
   localparam logic [1:0] OP_BOOL = 2'd1;
   localparam logic [1:0] OP_MOD  = 2'd2;

   localparam logic [31:0] SEED_MULT = 32'd69069;

   localparam logic [31:0] MASK_ONE   = 32'hFFFF_FFFE;
   localparam logic [31:0] MASK_TWO   = 32'hFFFF_FFF8;
   localparam logic [31:0] MASK_THREE = 32'hFFFF_FFF0;

   typedef struct packed {
      logic [31:0] c1;
      logic [31:0] c2;
      logic [31:0] c3;
   } taus_state_type;

   function automatic logic [31:0] taus_update(
      input logic [31:0] s,
      input int unsigned a,
      input int unsigned b,
      input logic [31:0] c,
      input int unsigned d
   );
      logic [31:0] mix;
      mix = ((s << a) ^ s) >> b;
      return ((s & c) << d) ^ mix;
   endfunction

endpackage

### sv/ctrng_taus_step.sv
// ----------------------------------------------------------------------------
// ctrng_taus_step
// one advance of all three tausworthe components and the combined word
// ----------------------------------------------------------------------------
module ctrng_taus_step (
   input  ctrng_pkg::taus_state_type cur,
   output ctrng_pkg::taus_state_type nxt,
   output logic [31:0]               word
);

   always_comb begin
      nxt.c1 = ctrng_pkg::taus_update(cur.c1, 13, 19, ctrng_pkg::MASK_ONE, 12);
      nxt.c2 = ctrng_pkg::taus_update(cur.c2, 2, 25, ctrng_pkg::MASK_TWO, 4);
      nxt.c3 = ctrng_pkg::taus_update(cur.c3, 3, 11, ctrng_pkg::MASK_THREE, 17);
      word   = nxt.c1 ^ nxt.c2 ^ nxt.c3;
   end

endmodule

### sv/ctrng_rem_unit.sv
// ----------------------------------------------------------------------------
// ctrng_rem_unit
// restoring remainder, one dividend bit per cycle over all 32 dividend bits
// ----------------------------------------------------------------------------
module ctrng_rem_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [30:0] divisor,
   output logic        done,
   output logic [30:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [30:0] dvs_ff, dvs_in;
   logic [30:0] rem_ff, rem_in;
   logic [31:0] trial;
   logic [30:0] diff;
   logic        ge;

   assign trial = {rem_ff, dvd_ff[31]};
   // difference is below the divisor whenever it is taken, so 31 bits hold it
   assign diff  = trial[30:0] - dvs_ff;
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         rem_in = ge ? diff : trial[30:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### sv/combined_tausworthe_rng_core.sv
// ----------------------------------------------------------------------------
// combined_tausworthe_rng_core
// three-component tausworthe generator with raw, bool and modulo outputs
// ----------------------------------------------------------------------------
// request channel (req_valid / req_stall, req_op, req_bound): each transfer
// advances all three components once and yields exactly one response on the
// rsp channel (rsp_valid / rsp_stall, rsp_value, rsp_error).
// for op raw and bool the result is registered at the request transfer and
// moves from ST_FINISH into the response register once that is free; the
// modulo op with a nonzero bound first runs the restoring remainder unit in
// ST_DIV. one request is in work at a time: req_stall is high from the
// transfer until the result is loaded into the response register, so a new
// request is never taken while an earlier one is still in work.
// a write on csr_wr_en loads every component with 69069 * seed and then runs
// three warm-up steps; req_stall stays high during those steps.
// reset clears the components to zero (generator stuck at zero) and empties
// the response register. a stalled response holds; a finished result waits
// in the sequencer until the response register is free.
// ----------------------------------------------------------------------------
module combined_tausworthe_rng_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [30:0] req_bound,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_error
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WARM   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] warm_cnt_ff, warm_cnt_in;
   ctrng_pkg::taus_state_type comps_ff, comps_in;
   ctrng_pkg::taus_state_type step_nxt;
   logic [31:0] step_word;
   logic [31:0] seed_mix;
   logic [31:0] res_value_ff, res_value_in;
   logic        res_error_ff, res_error_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_error_ff, rsp_error_in;
   logic        req_xfer;
   logic        rem_start;
   logic        rem_done;
   logic [30:0] rem_value;

   assign seed_mix = csr_wr_data * ctrng_pkg::SEED_MULT;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer = req_valid && !req_stall;
   assign rem_start = req_xfer && (req_op == ctrng_pkg::OP_MOD) && (req_bound != '0);

   ctrng_taus_step u_step (
      .cur  (comps_ff),
      .nxt  (step_nxt),
      .word (step_word)
   );

   ctrng_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (step_word),
      .divisor   (req_bound),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      state_in     = state_ff;
      warm_cnt_in  = warm_cnt_ff;
      comps_in     = comps_ff;
      res_value_in = res_value_ff;
      res_error_in = res_error_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      if (csr_wr_en) begin
         comps_in.c1 = seed_mix;
         comps_in.c2 = seed_mix;
         comps_in.c3 = seed_mix;
         warm_cnt_in = '0;
         state_in    = ST_WARM;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  comps_in     = step_nxt;
                  res_value_in = step_word;
                  res_error_in = 1'b0;
                  state_in     = ST_FINISH;
                  case (req_op)
                     ctrng_pkg::OP_BOOL: begin
                        res_value_in = {31'd0, step_word[0]};
                     end
                     ctrng_pkg::OP_MOD: begin
                        if (req_bound == '0) begin
                           res_value_in = '0;
                           res_error_in = 1'b1;
                        end else begin
                           state_in = ST_DIV;
                        end
                     end
                     default: begin
                        res_value_in = step_word;
                     end
                  endcase
               end
            end
            ST_WARM: begin
               comps_in    = step_nxt;
               warm_cnt_in = warm_cnt_ff + 2'd1;
               if (warm_cnt_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end
            end
            ST_DIV: begin
               if (rem_done) begin
                  res_value_in = {1'b0, rem_value};
                  res_error_in = 1'b0;
                  state_in     = ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = res_value_ff;
                  rsp_error_in = res_error_ff;
                  state_in     = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warm_cnt_ff  <= '0;
         comps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warm_cnt_ff  <= warm_cnt_in;
         comps_ff     <= comps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_value_ff <= res_value_in;
      res_error_ff <= res_error_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

`ifndef SYNTH
   a_rem_done_in_div: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> (state_ff == ST_DIV))
      else $error("remainder done outside divide state");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_value_ff == 32'd0))
      else $error("error response with nonzero value");

   a_zero_bound_flag: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !csr_wr_en && (req_op == ctrng_pkg::OP_MOD) && (req_bound == '0))
      |=> ((state_ff == ST_FINISH) && res_error_ff))
      else $error("zero bound did not raise error");

   a_warm_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WARM) |-> (warm_cnt_ff != 2'd3))
      else $error("warm-up ran past three steps");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the combined tausworthe generator: reseeds between
// phases, sends raw, bool, modulo and unused-op requests in bursts against a
// changing response stall pattern and checks every response against a model
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [31:0] value;
      logic        error;
   } draw_result_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [30:0] req_bound;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_value;
   logic        rsp_error;

   ctrng_pkg::taus_state_type gen_state;
   draw_result_type pending_draws[$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;
   int              stall_mode = 0;
   int              stall_mode_left = 0;
   logic [7:0]      stall_phase = '0;

   combined_tausworthe_rng_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_bound   (req_bound),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_error   (rsp_error)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_op = ctrng_pkg::OP_RAW;
      req_bound = '0;
      rsp_stall = 1'b0;
      gen_state = '0;
   end

   always #5 clock = ~clock;

   function automatic logic [31:0] advance_generator();
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = gen_state.c1;
      b = gen_state.c2;
      c = gen_state.c3;
      gen_state.c1 = ((a & ctrng_pkg::MASK_ONE) << 12) ^ (((a << 13) ^ a) >> 19);
      gen_state.c2 = ((b & ctrng_pkg::MASK_TWO) << 4) ^ (((b << 2) ^ b) >> 25);
      gen_state.c3 = ((c & ctrng_pkg::MASK_THREE) << 17) ^ (((c << 3) ^ c) >> 11);
      return gen_state.c1 ^ gen_state.c2 ^ gen_state.c3;
   endfunction

   function automatic void reseed_generator(logic [31:0] seed_value);
      logic [31:0] start;
      start = ctrng_pkg::SEED_MULT * seed_value;
      gen_state.c1 = start;
      gen_state.c2 = start;
      gen_state.c3 = start;
      repeat (3) void'(advance_generator());
   endfunction

   function automatic draw_result_type predict_draw(logic [1:0] op, logic [30:0] bound);
      draw_result_type r;
      logic [31:0]     word;
      word = advance_generator();
      r.value = word;
      r.error = 1'b0;
      case (op)
         ctrng_pkg::OP_BOOL: r.value = {31'b0, word[0]};
         ctrng_pkg::OP_MOD: begin
            if (bound == '0) begin
               r.value = '0;
               r.error = 1'b1;
            end else begin
               r.value = word % {1'b0, bound};
            end
         end
         default: r.value = word;
      endcase
      return r;
   endfunction

   // one request transfer, with bursts and random gaps on the sender side
   task automatic send_item(logic [1:0] op, logic [30:0] bound);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_op <= 2'($urandom);
            req_bound <= 31'($urandom);
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_bound <= bound;
      do @(posedge clock); while (req_stall);
      pending_draws.push_back(predict_draw(op, bound));
   endtask

   task automatic write_seed(logic [31:0] seed_value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= seed_value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 32'($urandom);
      reseed_generator(seed_value);
      burst_left = 0;
   endtask

   function automatic logic [1:0] pick_op();
      case ($urandom_range(0, 9))
         0, 1, 2:    return ctrng_pkg::OP_RAW;
         3, 4:       return ctrng_pkg::OP_BOOL;
         5, 6, 7, 8: return ctrng_pkg::OP_MOD;
         default:    return OP_UNUSED;
      endcase
   endfunction

   function automatic logic [30:0] pick_bound();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 31'h7FFF_FFFF;
         2:       return 31'd1;
         3:       return 31'(32'd1 << $urandom_range(0, 30));
         4, 5:    return 31'($urandom_range(1, 16));
         6:       return 31'($urandom_range(1, 1000));
         default: return 31'($urandom);
      endcase
   endfunction

   // components start at zero after reset, so every draw is zero
   task automatic test_reset_state();
      send_item(ctrng_pkg::OP_RAW, 31'h7FFF_FFFF);
      send_item(ctrng_pkg::OP_BOOL, '0);
      send_item(ctrng_pkg::OP_MOD, 31'd5);
      send_item(ctrng_pkg::OP_MOD, '0);
      send_item(OP_UNUSED, 31'h2AAA_AAAA);
   endtask

   task automatic test_zero_seed();
      write_seed(32'd0);
      send_item(ctrng_pkg::OP_RAW, 31'h5555_5555);
      send_item(ctrng_pkg::OP_MOD, 31'd7);
      send_item(ctrng_pkg::OP_BOOL, 31'd1);
   endtask

   task automatic test_field_extremes();
      write_seed(32'hFFFF_FFFF);
      send_item(ctrng_pkg::OP_RAW, '0);
      send_item(ctrng_pkg::OP_BOOL, 31'h7FFF_FFFF);
      send_item(ctrng_pkg::OP_MOD, 31'h7FFF_FFFF);
      send_item(ctrng_pkg::OP_MOD, 31'd1);
      send_item(ctrng_pkg::OP_MOD, '0);
      send_item(OP_UNUSED, '0);
      write_seed(32'd5);
      write_seed(32'd1);
      send_item(ctrng_pkg::OP_MOD, 31'h4000_0000);
      send_item(ctrng_pkg::OP_MOD, 31'd2);
      send_item(ctrng_pkg::OP_RAW, 31'h7FFF_FFFF);
      send_item(ctrng_pkg::OP_BOOL, '0);
      send_item(OP_UNUSED, 31'h7FFF_FFFF);
      send_item(ctrng_pkg::OP_MOD, 31'd3);
   endtask

   task automatic test_random_draws();
      logic [31:0] seed_value;
      int          count;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1:       seed_value = 32'hFFFF_FFFF;
            2:       seed_value = 32'd1;
            4:       seed_value = 32'd0;
            default: seed_value = $urandom;
         endcase
         write_seed(seed_value);
         count = (phase == 4) ? 30 : 164;
         for (int i = 0; i < count; i++) send_item(pick_op(), pick_bound());
      end
   endtask

   // response side stall pattern: off, light, heavy or periodic
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_mode_left <= $urandom_range(64, 512);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      stall_phase <= stall_phase + 1'b1;
      case (stall_mode)
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         3:       rsp_stall <= stall_phase[2];
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      draw_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            $error("unexpected transfer: value %h error %b", rsp_value, rsp_error);
            mismatch_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_value !== want.value) begin
               $error("value: expected %h actual %h", want.value, rsp_value);
               mismatch_count++;
            end
            if (rsp_error !== want.error) begin
               $error("error: expected %b actual %b", want.error, rsp_error);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[combined_tausworthe_rng_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_zero_seed();
      test_field_extremes();
      test_random_draws();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[combined_tausworthe_rng_core] OK");
      end else begin
         $display("[combined_tausworthe_rng_core] ERROR");
      end
      $finish;
   end

endmodule
